### rtl/core/character_plane_port_registers_core_defines.svh
// assertion macros shared by the character plane port register files
`ifndef CHARACTER_PLANE_PORT_REGISTERS_CORE_DEFINES_SVH
`define CHARACTER_PLANE_PORT_REGISTERS_CORE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define CPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define CPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cpr_pkg.sv
// shared types and constants of the character plane port register block
package cpr_pkg;

  localparam int WORD_W = 32;

  localparam int DEF_PALETTE_WORDS = 256;
  localparam int DEF_GLYPH_WORDS   = 4096;
  localparam int DEF_CELL_WORDS    = 1024;

  localparam logic [WORD_W-1:0] REV_COUNTER_RESET = 32'd3;
  localparam logic [WORD_W-1:0] PALETTE_STAMP_RESET = 32'd1;
  localparam logic [WORD_W-1:0] GLYPH_STAMP_RESET = 32'd2;
  localparam logic [WORD_W-1:0] CELL_STAMP_RESET = 32'd3;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [2:0] {
    REG_CONTROL   = 3'd0,
    REG_PAL_ADDR  = 3'd1,
    REG_PAL_DATA  = 3'd2,
    REG_GLY_ADDR  = 3'd3,
    REG_GLY_DATA  = 3'd4,
    REG_CEL_ADDR  = 3'd5,
    REG_CEL_DATA  = 3'd6,
    REG_UNMAPPED  = 3'd7
  } cpr_reg_t;

  // where the read word of a request in flight comes from
  typedef enum logic [1:0] {
    SRC_VALUE   = 2'd0,
    SRC_PALETTE = 2'd1,
    SRC_GLYPH   = 2'd2,
    SRC_CELL    = 2'd3
  } cpr_src_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_RUN   = 3'b010,
    ST_WRAP  = 3'b100
  } cpr_state_t;

  // status of the cell pointer reduction unit
  typedef struct packed {
    logic busy;
    logic done;
  } cpr_mod_stat_t;

endpackage

### rtl/core/cpr_word_ram.sv
// single-port-write, single-port-read word memory with registered read data
module cpr_word_ram #(
  parameter int WORDS = 256
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(WORDS)-1:0]   wr_addr,
  input  logic [cpr_pkg::WORD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(WORDS)-1:0]   rd_addr,
  output logic [cpr_pkg::WORD_W-1:0] rd_data
);
  import cpr_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/cpr_cell_wrap.sv
// remainder of a 32-bit cell pointer by the cell memory depth, reciprocal multiply
`include "character_plane_port_registers_core_defines.svh"

module cpr_cell_wrap #(
  parameter int CELL_WORDS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cpr_pkg::WORD_W-1:0] dividend,
  output cpr_pkg::cpr_mod_stat_t     stat,
  output logic [$clog2(CELL_WORDS)-1:0] rem
);
  import cpr_pkg::*;

  localparam int RW = $clog2(CELL_WORDS);
  localparam logic [RW:0] DIVISOR = (RW + 1)'(CELL_WORDS);
  localparam logic [WORD_W-1:0] DIV_WORD = WORD_W'(CELL_WORDS);
  // floor(2^32 / depth): the quotient estimate is exact or one short
  localparam logic [WORD_W-1:0] RECIP = WORD_W'(64'h1_0000_0000 / 64'(CELL_WORDS));

  logic                busy;
  logic                done;
  logic [2:0]          stage_vld;   // estimate, residue, correction
  logic [WORD_W-1:0]   num;
  logic [WORD_W-1:0]   quo_est;
  logic [RW:0]         residue;
  logic [2*WORD_W-1:0] recip_prod;
  logic [WORD_W-1:0]   back_prod;
  logic [WORD_W-1:0]   diff;

  // residue is below twice the depth, so one compare and subtract finishes it
  always_comb begin
    recip_prod = (2*WORD_W)'(num) * (2*WORD_W)'(RECIP);
    back_prod  = quo_est * DIV_WORD;
    diff       = num - back_prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      stage_vld <= '0;
    end else begin
      stage_vld <= {stage_vld[1:0], start};
      done      <= stage_vld[2];
      if (start) begin
        busy <= 1'b1;
      end else if (stage_vld[2]) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (stage_vld[0]) begin
      quo_est <= recip_prod[2*WORD_W-1:WORD_W];
    end
    if (stage_vld[1]) begin
      residue <= diff[RW:0];
    end
    if (stage_vld[2]) begin
      rem <= (residue >= DIVISOR) ? RW'(residue - DIVISOR) : residue[RW-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `CPR_ASSERT_NOW(wrap_no_restart, start, !busy, "cell wrap restarted while busy")
  `CPR_ASSERT_NEXT(wrap_start_busy, start, busy, "cell wrap did not start")
  `CPR_ASSERT_NOW(wrap_rem_range, done, 32'(rem) < 32'(CELL_WORDS), "cell remainder range")

endmodule

### rtl/core/character_plane_port_registers_core.sv
// top level of the character plane port register block
// Bus-side register file of a character display plane. Each request reads
// or writes the control word or one of three address/data port pairs
// (palette, glyph, cell); a data port access uses its pointer wrapped into
// range and then advances it. Every data write bumps a shared revision
// counter that stamps the memory written.
// Channels: request (req_valid/req_stall with req_type, reg_select,
// write_data) and response (rsp_valid/rsp_stall, one response per request).
// Response path: the edge that takes a request reads the word memory into the
// stage, and the response register loads from that stage unless a response is held.
// Throughput: one request per cycle while req_stall is low. A cell address
// write whose value is not below CELL_WORDS runs a three-step reciprocal
// remainder, and req_stall stays high until the remainder is written back.
// Reset: the three word memories are swept to zero, one word of each per
// cycle, over max(PALETTE_WORDS, GLYPH_WORDS, CELL_WORDS) addresses (4096 at
// the defaults) while req_stall is high; registers reset at once.
// A stalled response holds; one more request is taken into the stage in
// front of the response register, then req_stall rises until it drains.
`include "character_plane_port_registers_core_defines.svh"

module character_plane_port_registers_core #(
  parameter int PALETTE_WORDS = cpr_pkg::DEF_PALETTE_WORDS,
  parameter int GLYPH_WORDS   = cpr_pkg::DEF_GLYPH_WORDS,
  parameter int CELL_WORDS    = cpr_pkg::DEF_CELL_WORDS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       req_type,
  input  logic [2:0]                 reg_select,
  input  logic [cpr_pkg::WORD_W-1:0] write_data,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [cpr_pkg::WORD_W-1:0] read_data,
  output logic [cpr_pkg::WORD_W-1:0] control_value,
  output logic [cpr_pkg::WORD_W-1:0] palette_revision,
  output logic [cpr_pkg::WORD_W-1:0] glyph_revision,
  output logic [cpr_pkg::WORD_W-1:0] cell_revision,
  output logic                       bad_register
);
  import cpr_pkg::*;

  localparam int PAW = $clog2(PALETTE_WORDS);
  localparam int GAW = $clog2(GLYPH_WORDS);
  localparam int CAW = $clog2(CELL_WORDS);
  localparam logic [PAW-1:0] PAL_MASK = PAW'(PALETTE_WORDS - 1);
  localparam logic [GAW-1:0] GLY_MASK = GAW'(GLYPH_WORDS - 1);
  localparam logic [CAW-1:0] CEL_LAST = CAW'(CELL_WORDS - 1);
  localparam int CLEAR_WORDS =
    (PALETTE_WORDS > GLYPH_WORDS) ?
      ((PALETTE_WORDS > CELL_WORDS) ? PALETTE_WORDS : CELL_WORDS) :
      ((GLYPH_WORDS > CELL_WORDS) ? GLYPH_WORDS : CELL_WORDS);
  localparam int CLW = $clog2(CLEAR_WORDS);

  // control and architectural state
  cpr_state_t        state, state_next;
  logic [CLW-1:0]    clear_idx;
  logic [WORD_W-1:0] control_word, control_word_next;
  logic [WORD_W-1:0] palette_pointer, palette_pointer_next;
  logic [WORD_W-1:0] glyph_pointer, glyph_pointer_next;
  logic [WORD_W-1:0] cell_pointer, cell_pointer_next;
  logic [CAW-1:0]    cell_index, cell_index_next;   // cell_pointer mod CELL_WORDS
  logic [WORD_W-1:0] revision_counter, revision_counter_next;
  logic [WORD_W-1:0] palette_stamp, palette_stamp_next;
  logic [WORD_W-1:0] glyph_stamp, glyph_stamp_next;
  logic [WORD_W-1:0] cell_stamp, cell_stamp_next;

  // stage between request and response: memory read data lands here
  logic              s1_valid;
  logic              s1_advance;
  logic              s1_held;
  cpr_src_t          s1_src, s1_src_next;
  logic [WORD_W-1:0] s1_value, s1_value_next;
  logic              s1_bad, s1_bad_next;
  logic [WORD_W-1:0] s1_control, s1_pal_rev, s1_gly_rev, s1_cel_rev;

  logic              accept;
  logic              is_write;
  cpr_reg_t          sel;
  logic              clearing;
  logic              clear_last;
  logic [WORD_W-1:0] rev_inc;
  logic              data_wr;

  logic [PAW-1:0]    pal_idx, pal_adv;
  logic [GAW-1:0]    gly_idx, gly_adv;
  logic [CAW-1:0]    cel_adv;

  logic              pal_wr_req, pal_rd_req, pal_wr_en;
  logic              gly_wr_req, gly_rd_req, gly_wr_en;
  logic              cel_wr_req, cel_rd_req, cel_wr_en;
  logic [PAW-1:0]    pal_wr_addr;
  logic [GAW-1:0]    gly_wr_addr;
  logic [CAW-1:0]    cel_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;
  logic [WORD_W-1:0] pal_rd_data, gly_rd_data, cel_rd_data;

  logic              mod_start;
  cpr_mod_stat_t     mod_stat;
  logic [CAW-1:0]    mod_rem;

  // handshake: the stage ahead of the response register takes a request in
  // ST_RUN when it is empty or drains in the same cycle
  assign s1_advance = !rsp_valid || !rsp_stall;
  assign s1_held    = s1_valid && !s1_advance;
  assign req_stall  = (state != ST_RUN) || (s1_valid && !s1_advance);
  assign accept     = req_valid && !req_stall;
  assign is_write   = (req_type == REQ_WRITE);
  assign sel        = cpr_reg_t'(reg_select);
  assign clearing   = (state == ST_CLEAR);
  assign clear_last = (clear_idx == CLW'(CLEAR_WORDS - 1));
  assign rev_inc    = revision_counter + 32'd1;
  assign data_wr    = pal_wr_req || gly_wr_req || cel_wr_req;

  // pointer wrap: mask for palette and glyph, held remainder for cells
  assign pal_idx = palette_pointer[PAW-1:0] & PAL_MASK;
  assign pal_adv = (pal_idx + PAW'(1)) & PAL_MASK;
  assign gly_idx = glyph_pointer[GAW-1:0] & GLY_MASK;
  assign gly_adv = (gly_idx + GAW'(1)) & GLY_MASK;
  assign cel_adv = (cell_index == CEL_LAST) ? '0 : (cell_index + CAW'(1));

  // register decode and next state of the register file
  always_comb begin
    control_word_next     = control_word;
    palette_pointer_next  = palette_pointer;
    glyph_pointer_next    = glyph_pointer;
    cell_pointer_next     = cell_pointer;
    cell_index_next       = cell_index;
    revision_counter_next = revision_counter;
    palette_stamp_next    = palette_stamp;
    glyph_stamp_next      = glyph_stamp;
    cell_stamp_next       = cell_stamp;
    pal_wr_req = 1'b0;
    pal_rd_req = 1'b0;
    gly_wr_req = 1'b0;
    gly_rd_req = 1'b0;
    cel_wr_req = 1'b0;
    cel_rd_req = 1'b0;
    mod_start  = 1'b0;
    s1_src_next   = SRC_VALUE;
    s1_value_next = '0;
    s1_bad_next   = 1'b0;
    if (accept) begin
      unique case (sel)
        REG_CONTROL: begin
          if (is_write) begin
            control_word_next = write_data;
          end else begin
            s1_value_next = control_word;
          end
        end
        REG_PAL_ADDR: begin
          if (is_write) begin
            palette_pointer_next = write_data;
          end else begin
            s1_value_next = palette_pointer;
          end
        end
        REG_PAL_DATA: begin
          palette_pointer_next = WORD_W'(pal_adv);
          if (is_write) begin
            pal_wr_req            = 1'b1;
            revision_counter_next = rev_inc;
            palette_stamp_next    = rev_inc;
          end else begin
            pal_rd_req  = 1'b1;
            s1_src_next = SRC_PALETTE;
          end
        end
        REG_GLY_ADDR: begin
          if (is_write) begin
            glyph_pointer_next = write_data;
          end else begin
            s1_value_next = glyph_pointer;
          end
        end
        REG_GLY_DATA: begin
          glyph_pointer_next = WORD_W'(gly_adv);
          if (is_write) begin
            gly_wr_req            = 1'b1;
            revision_counter_next = rev_inc;
            glyph_stamp_next      = rev_inc;
          end else begin
            gly_rd_req  = 1'b1;
            s1_src_next = SRC_GLYPH;
          end
        end
        REG_CEL_ADDR: begin
          if (is_write) begin
            cell_pointer_next = write_data;
            // in-range pointers need no reduction
            if (write_data < 32'(CELL_WORDS)) begin
              cell_index_next = write_data[CAW-1:0];
            end else begin
              mod_start = 1'b1;
            end
          end else begin
            s1_value_next = cell_pointer;
          end
        end
        REG_CEL_DATA: begin
          cell_pointer_next = WORD_W'(cel_adv);
          cell_index_next   = cel_adv;
          if (is_write) begin
            cel_wr_req            = 1'b1;
            revision_counter_next = rev_inc;
            cell_stamp_next       = rev_inc;
          end else begin
            cel_rd_req  = 1'b1;
            s1_src_next = SRC_CELL;
          end
        end
        REG_UNMAPPED: begin
          s1_bad_next = 1'b1;
        end
      endcase
    end
    if (mod_stat.done) begin
      cell_index_next = mod_rem;
    end
  end

  // sequencer: clearing sweep, normal run, wait for cell pointer reduction
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (mod_start) begin
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (mod_stat.done) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clear_idx        <= '0;
      control_word     <= '0;
      palette_pointer  <= '0;
      glyph_pointer    <= '0;
      cell_pointer     <= '0;
      cell_index       <= '0;
      revision_counter <= REV_COUNTER_RESET;
      palette_stamp    <= PALETTE_STAMP_RESET;
      glyph_stamp      <= GLYPH_STAMP_RESET;
      cell_stamp       <= CELL_STAMP_RESET;
    end else begin
      state            <= state_next;
      if (clearing && !clear_last) begin
        clear_idx <= clear_idx + CLW'(1);
      end
      control_word     <= control_word_next;
      palette_pointer  <= palette_pointer_next;
      glyph_pointer    <= glyph_pointer_next;
      cell_pointer     <= cell_pointer_next;
      cell_index       <= cell_index_next;
      revision_counter <= revision_counter_next;
      palette_stamp    <= palette_stamp_next;
      glyph_stamp      <= glyph_stamp_next;
      cell_stamp       <= cell_stamp_next;
    end
  end

  // memory write ports: the reset sweep writes zeros, then requests write
  assign mem_wr_data = clearing ? '0 : write_data;
  assign pal_wr_en   = (clearing && (32'(clear_idx) < 32'(PALETTE_WORDS))) || pal_wr_req;
  assign gly_wr_en   = (clearing && (32'(clear_idx) < 32'(GLYPH_WORDS))) || gly_wr_req;
  assign cel_wr_en   = (clearing && (32'(clear_idx) < 32'(CELL_WORDS))) || cel_wr_req;
  assign pal_wr_addr = clearing ? clear_idx[PAW-1:0] : pal_idx;
  assign gly_wr_addr = clearing ? clear_idx[GAW-1:0] : gly_idx;
  assign cel_wr_addr = clearing ? clear_idx[CAW-1:0] : cell_index;

  cpr_word_ram #(
    .WORDS (PALETTE_WORDS)
  ) u_palette_ram (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (pal_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (pal_rd_req),
    .rd_addr (pal_idx),
    .rd_data (pal_rd_data)
  );

  cpr_word_ram #(
    .WORDS (GLYPH_WORDS)
  ) u_glyph_ram (
    .clk     (clk),
    .wr_en   (gly_wr_en),
    .wr_addr (gly_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (gly_rd_req),
    .rd_addr (gly_idx),
    .rd_data (gly_rd_data)
  );

  cpr_word_ram #(
    .WORDS (CELL_WORDS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (cel_wr_en),
    .wr_addr (cel_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (cel_rd_req),
    .rd_addr (cell_index),
    .rd_data (cel_rd_data)
  );

  cpr_cell_wrap #(
    .CELL_WORDS (CELL_WORDS)
  ) u_cell_wrap (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (write_data),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  // request in flight: register values after this access are captured here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src     <= s1_src_next;
      s1_value   <= s1_value_next;
      s1_bad     <= s1_bad_next;
      s1_control <= control_word_next;
      s1_pal_rev <= palette_stamp_next;
      s1_gly_rev <= glyph_stamp_next;
      s1_cel_rev <= cell_stamp_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      case (s1_src)
        SRC_PALETTE: read_data <= pal_rd_data;
        SRC_GLYPH:   read_data <= gly_rd_data;
        SRC_CELL:    read_data <= cel_rd_data;
        default:     read_data <= s1_value;
      endcase
      control_value    <= s1_control;
      palette_revision <= s1_pal_rev;
      glyph_revision   <= s1_gly_rev;
      cell_revision    <= s1_cel_rev;
      bad_register     <= s1_bad;
    end
  end

  `CPR_ASSERT_NEXT(rev_bump, data_wr, revision_counter == $past(rev_inc), "revision not bumped")
  `CPR_ASSERT_NOW(wrap_wait, state == ST_WRAP, mod_stat.busy || mod_stat.done, "wrap unit idle")
  `CPR_ASSERT_NOW(cell_idx_range, 1'b1, 32'(cell_index) < 32'(CELL_WORDS), "cell index range")
  `CPR_ASSERT_NEXT(s1_hold, s1_held, s1_valid && $stable(s1_src) && $stable(s1_value), "request lost")

endmodule

### dv/cpr_port_scoreboard_pkg.sv
// scoreboard class that predicts and checks port register responses
`timescale 1ns / 100ps

package cpr_port_scoreboard_pkg;
  import cpr_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [WORD_W-1:0] control_word;
    logic [WORD_W-1:0] palette_rev;
    logic [WORD_W-1:0] glyph_rev;
    logic [WORD_W-1:0] cell_rev;
    logic              unmapped;
  } port_response_t;

  class cpr_port_scoreboard;
    localparam int PAL_N = DEF_PALETTE_WORDS;
    localparam int GLY_N = DEF_GLYPH_WORDS;
    localparam int CEL_N = DEF_CELL_WORDS;

    logic [WORD_W-1:0] ctrl_word;
    logic [WORD_W-1:0] pal_ptr;
    logic [WORD_W-1:0] gly_ptr;
    logic [WORD_W-1:0] cel_ptr;
    logic [WORD_W-1:0] pal_mem [PAL_N];
    logic [WORD_W-1:0] gly_mem [GLY_N];
    logic [WORD_W-1:0] cel_mem [CEL_N];
    logic [WORD_W-1:0] revision_count;
    logic [WORD_W-1:0] pal_rev;
    logic [WORD_W-1:0] gly_rev;
    logic [WORD_W-1:0] cel_rev;

    port_response_t pending_responses[$];
    int mismatches;

    function new();
      ctrl_word = '0;
      pal_ptr = '0;
      gly_ptr = '0;
      cel_ptr = '0;
      foreach (pal_mem[i]) pal_mem[i] = '0;
      foreach (gly_mem[i]) gly_mem[i] = '0;
      foreach (cel_mem[i]) cel_mem[i] = '0;
      revision_count = REV_COUNTER_RESET;
      pal_rev = PALETTE_STAMP_RESET;
      gly_rev = GLYPH_STAMP_RESET;
      cel_rev = CELL_STAMP_RESET;
      mismatches = 0;
    endfunction

    // applies one request to the shadow registers and returns its response
    function port_response_t predict_access(logic kind, cpr_reg_t sel,
                                            logic [WORD_W-1:0] wdata);
      port_response_t rsp;
      logic [WORD_W-1:0] idx;
      logic is_wr;
      is_wr = (kind == REQ_WRITE);
      rsp = '0;
      case (sel)
        REG_CONTROL: begin
          if (is_wr) ctrl_word = wdata; else rsp.read_word = ctrl_word;
        end
        REG_PAL_ADDR: begin
          if (is_wr) pal_ptr = wdata; else rsp.read_word = pal_ptr;
        end
        REG_PAL_DATA: begin
          idx = pal_ptr & (PAL_N - 1);
          if (is_wr) begin
            pal_mem[idx] = wdata;
            revision_count = revision_count + 1;
            pal_rev = revision_count;
          end else begin
            rsp.read_word = pal_mem[idx];
          end
          pal_ptr = (idx + 1) & (PAL_N - 1);
        end
        REG_GLY_ADDR: begin
          if (is_wr) gly_ptr = wdata; else rsp.read_word = gly_ptr;
        end
        REG_GLY_DATA: begin
          idx = gly_ptr & (GLY_N - 1);
          if (is_wr) begin
            gly_mem[idx] = wdata;
            revision_count = revision_count + 1;
            gly_rev = revision_count;
          end else begin
            rsp.read_word = gly_mem[idx];
          end
          gly_ptr = (idx + 1) & (GLY_N - 1);
        end
        REG_CEL_ADDR: begin
          if (is_wr) cel_ptr = wdata; else rsp.read_word = cel_ptr;
        end
        REG_CEL_DATA: begin
          idx = cel_ptr % CEL_N;
          if (is_wr) begin
            cel_mem[idx] = wdata;
            revision_count = revision_count + 1;
            cel_rev = revision_count;
          end else begin
            rsp.read_word = cel_mem[idx];
          end
          cel_ptr = (idx + 1 == CEL_N) ? '0 : idx + 1;
        end
        default: begin
          rsp.unmapped = 1'b1;
        end
      endcase
      if (is_wr) rsp.read_word = '0;
      rsp.control_word = ctrl_word;
      rsp.palette_rev = pal_rev;
      rsp.glyph_rev = gly_rev;
      rsp.cell_rev = cel_rev;
      return rsp;
    endfunction

    function void note_request(logic kind, cpr_reg_t sel, logic [WORD_W-1:0] wdata);
      pending_responses.push_back(predict_access(kind, sel, wdata));
    endfunction

    function int pending();
      return pending_responses.size();
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] exp_val,
                                logic [WORD_W-1:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_response(logic [WORD_W-1:0] rdata, logic [WORD_W-1:0] ctrl,
                                 logic [WORD_W-1:0] prev, logic [WORD_W-1:0] grev,
                                 logic [WORD_W-1:0] crev, logic bad);
      port_response_t exp_rsp;
      if (pending_responses.size() == 0) begin
        $display("%0t: response with no request outstanding, expected none actual %h",
                 $time, rdata);
        mismatches++;
        return;
      end
      exp_rsp = pending_responses.pop_front();
      compare_field("read_data", exp_rsp.read_word, rdata);
      compare_field("control_value", exp_rsp.control_word, ctrl);
      compare_field("palette_revision", exp_rsp.palette_rev, prev);
      compare_field("glyph_revision", exp_rsp.glyph_rev, grev);
      compare_field("cell_revision", exp_rsp.cell_rev, crev);
      compare_field("bad_register", {31'd0, exp_rsp.unmapped}, {31'd0, bad});
    endfunction
  endclass

endpackage

### dv/tb_character_plane_port_registers_core.sv
// testbench top that drives random port register requests and checks responses
`timescale 1ns / 100ps

module tb_character_plane_port_registers_core;
  import cpr_pkg::*;
  import cpr_port_scoreboard_pkg::*;

  // the limit covers the clearing pass, slow gaps, stalls and the cell address
  // reduction many times over
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 550;
  localparam int LONG_HOLD_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic              req_type;
  logic [2:0]        reg_select;
  logic [WORD_W-1:0] write_data;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [WORD_W-1:0] read_data;
  logic [WORD_W-1:0] control_value;
  logic [WORD_W-1:0] palette_revision;
  logic [WORD_W-1:0] glyph_revision;
  logic [WORD_W-1:0] cell_revision;
  logic              bad_register;

  cpr_port_scoreboard sb;

  int  cycle_count;
  int  requests_sent;
  bit  quiet;          // no gaps or stalls on either side while set, but for a long hold-off
  bit  long_hold_req;  // asks the response side for one long hold-off
  int  hold_left;
  int  stall_left;
  int  free_left;

  character_plane_port_registers_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req_type         (req_type),
    .reg_select       (reg_select),
    .write_data       (write_data),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .read_data        (read_data),
    .control_value    (control_value),
    .palette_revision (palette_revision),
    .glyph_revision   (glyph_revision),
    .cell_revision    (cell_revision),
    .bad_register     (bad_register)
  );

  always #5 clk = ~clk;

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // pointer values: mostly in range, some near the top, a few full width
  function automatic logic [WORD_W-1:0] pick_pointer(int words);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, words - 1);
    if (r < 90) return words - 1 - $urandom_range(0, 3);
    return $urandom;
  endfunction

  // offers one request and returns at the edge that takes it
  task automatic send_request(logic kind, cpr_reg_t sel, logic [WORD_W-1:0] wdata);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    reg_select <= sel;
    write_data <= wdata;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(kind, sel, wdata);
    requests_sent++;
  endtask

  // sets a pointer, runs data accesses, optionally rewinds and reads them back
  task automatic run_port_burst(cpr_reg_t addr_reg, cpr_reg_t data_reg, int words);
    logic [WORD_W-1:0] start_ptr;
    int count;
    start_ptr = pick_pointer(words);
    count = $urandom_range(1, 8);
    send_request(REQ_WRITE, addr_reg, start_ptr);
    for (int i = 0; i < count; i++) begin
      send_request($urandom_range(0, 3) != 0 ? REQ_WRITE : REQ_READ, data_reg, $urandom);
    end
    if ($urandom_range(0, 1) == 1) begin
      send_request(REQ_WRITE, addr_reg, start_ptr);
      for (int i = 0; i < count; i++) send_request(REQ_READ, data_reg, $urandom);
    end
    if ($urandom_range(0, 3) == 0) send_request(REQ_READ, addr_reg, $urandom);
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("character_plane_port_registers_core regression: fail");
      $finish;
    end
  end

  // response side: checks every taken response and drives rsp_stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_response(read_data, control_value, palette_revision, glyph_revision,
                        cell_revision, bad_register);
    end
    if (long_hold_req) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      // long hold-off so the pipeline fills and the request side stalls
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (quiet) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      rsp_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      free_left = $urandom_range(1, 12);
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    int r;
    cpr_reg_t sel;
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_READ;
    reg_select = REG_CONTROL;
    write_data = '0;
    rsp_stall = 1'b0;
    cycle_count = 0;
    requests_sent = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    free_left = 0;
    sb = new();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values and control extremes
    send_request(REQ_READ, REG_CONTROL, 32'h0);
    send_request(REQ_WRITE, REG_CONTROL, 32'hffff_ffff);
    send_request(REQ_READ, REG_CONTROL, 32'h0);
    send_request(REQ_WRITE, REG_CONTROL, 32'h0);
    // palette pointer out of range is masked, address port keeps full value
    send_request(REQ_WRITE, REG_PAL_ADDR, 32'hffff_ffff);
    send_request(REQ_READ, REG_PAL_ADDR, 32'h0);
    send_request(REQ_WRITE, REG_PAL_DATA, 32'hffff_ffff);
    send_request(REQ_READ, REG_PAL_DATA, 32'h0);
    // glyph pointer wraps from the last word to zero
    send_request(REQ_WRITE, REG_GLY_ADDR, 32'h0000_0fff);
    send_request(REQ_WRITE, REG_GLY_DATA, 32'ha5a5_a5a5);
    send_request(REQ_READ, REG_GLY_ADDR, 32'h0);
    // cell pointer at the last word, then wrap on advance
    send_request(REQ_WRITE, REG_CEL_ADDR, DEF_CELL_WORDS - 1);
    send_request(REQ_WRITE, REG_CEL_DATA, 32'h5a5a_5a5a);
    send_request(REQ_READ, REG_CEL_ADDR, 32'h0);
    // cell pointer beyond range takes the slow remainder path
    send_request(REQ_WRITE, REG_CEL_ADDR, 32'hffff_ffff);
    send_request(REQ_READ, REG_CEL_DATA, 32'h0);
    send_request(REQ_WRITE, REG_CEL_ADDR, DEF_CELL_WORDS);
    send_request(REQ_READ, REG_CEL_DATA, 32'h0);
    // unmapped register, both directions
    send_request(REQ_READ, REG_UNMAPPED, 32'h0);
    send_request(REQ_WRITE, REG_UNMAPPED, 32'hffff_ffff);
    // read back the top palette word and a masked glyph pointer
    send_request(REQ_WRITE, REG_PAL_ADDR, DEF_PALETTE_WORDS - 1);
    send_request(REQ_READ, REG_PAL_DATA, 32'h0);
    send_request(REQ_WRITE, REG_GLY_ADDR, 32'h1234_5fff);
    send_request(REQ_READ, REG_GLY_DATA, 32'h0);
    send_request(REQ_WRITE, REG_GLY_DATA, 32'h0);

    // back-pressure: the response side holds off while requests keep coming
    quiet = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                   cpr_reg_t'($urandom_range(0, 6)), $urandom);
    end
    quiet = 1'b0;

    // random traffic, mostly well-formed pointer/data bursts
    while (requests_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 20) begin
        run_port_burst(REG_PAL_ADDR, REG_PAL_DATA, DEF_PALETTE_WORDS);
      end else if (r < 40) begin
        run_port_burst(REG_GLY_ADDR, REG_GLY_DATA, DEF_GLYPH_WORDS);
      end else if (r < 60) begin
        run_port_burst(REG_CEL_ADDR, REG_CEL_DATA, DEF_CELL_WORDS);
      end else if (r < 70) begin
        send_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, REG_CONTROL, $urandom);
      end else if (r < 80) begin
        case ($urandom_range(0, 2))
          0: sel = REG_PAL_ADDR;
          1: sel = REG_GLY_ADDR;
          default: sel = REG_CEL_ADDR;
        endcase
        send_request(REQ_READ, sel, $urandom);
      end else if (r < 85) begin
        send_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, REG_UNMAPPED, $urandom);
      end else begin
        // noise, any register and any data
        send_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                     cpr_reg_t'($urandom_range(0, 7)), $urandom);
      end
    end
    quiet = 1'b0;
    req_valid <= 1'b0;

    // drain, then keep the clock running to catch any stray response
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("character_plane_port_registers_core regression: pass");
    end else begin
      $display("character_plane_port_registers_core regression: fail");
    end
    $finish;
  end

endmodule
